>>> hw/rtl/ntc_temperature_qualifier_defines.svh
`ifndef NTC_TEMPERATURE_QUALIFIER_DEFINES_SVH
`define NTC_TEMPERATURE_QUALIFIER_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define NTCQ_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ntcq assertion failed");

// Next-cycle implication, sampled on clk_i, off during reset.
`define NTCQ_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ntcq assertion failed");

`endif

>>> hw/rtl/ntcq_pkg.sv
`default_nettype none

package ntcq_pkg;

  localparam int NUM_W   = 32;
  localparam int ADC_W   = 16;
  localparam int RB_W    = 20;
  localparam int OFS_W   = 5;
  localparam int TEMP_W  = 8;
  localparam int CFG_W   = 32;
  localparam int CFG_IDX_W = 3;

  localparam int ROM_SIZE = 70;
  localparam int ROM_AW   = 7;
  localparam int RES_W    = 14;

  typedef enum logic [1:0] {
    ST_VALID  = 2'd0,
    ST_SENSOR = 2'd1,
    ST_HIGH   = 2'd2,
    ST_LOW    = 2'd3
  } status_e;

  localparam logic [CFG_IDX_W-1:0] CFG_DIV_NUM   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BYPASS    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ERR_CODE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TIME = 3'd4;

  // Divider resistance per degree, falling from the base temperature upward.
  localparam logic [RES_W-1:0] RES_ROM [ROM_SIZE] = '{
    14'd12160, 14'd11520, 14'd10920, 14'd10350, 14'd9820,
    14'd9316,  14'd8841,  14'd8392,  14'd7968,  14'd7568,
    14'd7190,  14'd6833,  14'd6495,  14'd6175,  14'd5873,
    14'd5587,  14'd5315,  14'd5060,  14'd4818,  14'd4589,
    14'd4372,  14'd4167,  14'd3972,  14'd3788,  14'd3613,
    14'd3447,  14'd3290,  14'd3141,  14'd2999,  14'd2865,
    14'd2737,  14'd2616,  14'd2501,  14'd2391,  14'd2287,
    14'd2188,  14'd2094,  14'd2005,  14'd1919,  14'd1838,
    14'd1761,  14'd1687,  14'd1617,  14'd1550,  14'd1486,
    14'd1426,  14'd1368,  14'd1312,  14'd1259,  14'd1209,
    14'd1161,  14'd1115,  14'd1071,  14'd1029,  14'd989,
    14'd951,   14'd914,   14'd879,   14'd845,   14'd813,
    14'd783,   14'd753,   14'd725,   14'd698,   14'd672,
    14'd647,   14'd624,   14'd601,   14'd579,   14'd559
  };

endpackage

`default_nettype wire

>>> hw/rtl/ntc_temperature_qualifier.sv
`default_nettype none

// Channel | Direction | Handshake            | Payload
// in      | input     | in_valid_i/in_ready_o | req_type_i, adc_code_i, time_ms_i
// out     | output    | out_valid_o/out_ready_i | temperature_o, status_o, updated_o, is_reply_o
// cfg     | input     | cfg_we_i (no wait)    | cfg_idx_i, cfg_data_i
//
// One item at a time. An in-table sample passes accept, divide, binary search, filter and
// output load; a sample whose r is out of table skips the search; error and zero codes go
// from accept straight to filter and output load; a read request goes from accept to output.
// Reset (async, active low) clears all state but the divider's data registers; no clearing pass.
// A stalled output holds the block in its output state until the item is taken.

module ntc_temperature_qualifier #(
  parameter int TABLE_ENTRIES = 70,
  parameter int BASE_TEMP     = -12
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [ntcq_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [ntcq_pkg::CFG_W-1:0]     cfg_data_i,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic                           req_type_i,
  input  wire logic [ntcq_pkg::ADC_W-1:0]     adc_code_i,
  input  wire logic [31:0]                    time_ms_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic signed [ntcq_pkg::TEMP_W-1:0]  temperature_o,
  output logic [1:0]                          status_o,
  output logic                                updated_o,
  output logic                                is_reply_o
);

  localparam int N = (TABLE_ENTRIES > ntcq_pkg::ROM_SIZE) ? ntcq_pkg::ROM_SIZE :
                     ((TABLE_ENTRIES < 2) ? 2 : TABLE_ENTRIES);
  localparam int IDX_W  = $clog2(N);
  localparam int RES_W  = ntcq_pkg::RES_W;
  localparam int TW     = ntcq_pkg::TEMP_W;
  localparam logic signed [ntcq_pkg::NUM_W:0] R_MAX =
    (ntcq_pkg::NUM_W + 1)'(ntcq_pkg::RES_ROM[0]);
  localparam logic signed [ntcq_pkg::NUM_W:0] R_MIN =
    (ntcq_pkg::NUM_W + 1)'(ntcq_pkg::RES_ROM[N-1]);
  localparam logic signed [TW:0] BASE9   = (TW+1)'(BASE_TEMP);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_SEARCH,
    S_FILTER,
    S_OUT
  } state_e;

  state_e state_q;

  logic [ntcq_pkg::NUM_W-1:0] div_num_q;
  logic [ntcq_pkg::RB_W-1:0]  bypass_q;
  logic [ntcq_pkg::ADC_W-1:0] err_code_q;
  logic [ntcq_pkg::OFS_W-1:0] offset_q;
  logic [31:0]                hold_time_q;

  logic signed [TW-1:0] held_temp_q;
  ntcq_pkg::status_e    held_st_q;
  logic [31:0]          accum_q;
  logic [31:0]          last_q;
  logic                 pending_q;

  logic                 req_q;
  logic [31:0]          time_q;
  ntcq_pkg::status_e    st_q;
  logic signed [TW-1:0] t_q;
  logic [RES_W-1:0]     r_q;
  logic [IDX_W-1:0]     lo_q;
  logic [IDX_W-1:0]     hi_q;
  logic                 upd_q;

  logic                 out_valid_q;
  logic signed [TW-1:0] out_temp_q;
  logic [1:0]           out_st_q;
  logic                 out_upd_q;
  logic                 out_reply_q;

  logic                 in_fire;
  logic                 div_start;
  logic                 div_done;
  logic [ntcq_pkg::NUM_W-1:0] quotient;
  logic signed [ntcq_pkg::NUM_W:0] r_full;
  logic [IDX_W:0]       mid_sum;
  logic [IDX_W-1:0]     mid;
  logic                 mid_ok;
  logic signed [TW:0]   temp9;
  logic                 out_free;
  logic                 out_load;

  logic                 f_changed;
  logic signed [TW:0]   f_diff;
  logic [31:0]          f_delta;
  logic [32:0]          f_sum;
  logic [31:0]          f_sat;
  logic                 f_take;
  logic                 f_pend;
  logic [31:0]          f_accum;
  logic [31:0]          f_last;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign div_start  = in_fire && !req_type_i && (adc_code_i != err_code_q)
                      && (adc_code_i != '0);
  assign out_free   = !out_valid_q || out_ready_i;
  assign out_load   = (state_q == S_OUT) && out_free;

  ntcq_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_num_q),
    .divisor_i  (adc_code_i),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  always_comb begin
    r_full  = $signed({1'b0, quotient}) -
              $signed({(ntcq_pkg::NUM_W + 1 - ntcq_pkg::RB_W)'(0), bypass_q});
    mid_sum = {1'b0, lo_q} + {1'b0, hi_q} + 1'b1;
    mid     = mid_sum[IDX_W:1];
    mid_ok  = ntcq_pkg::RES_ROM[ntcq_pkg::ROM_AW'(mid)] >= r_q;
    temp9   = BASE9 + $signed((TW+1)'(lo_q))
              + $signed({{(TW+1-ntcq_pkg::OFS_W){offset_q[ntcq_pkg::OFS_W-1]}}, offset_q});
  end

  // Hold filter
  always_comb begin
    f_changed = (st_q != held_st_q) || (t_q != held_temp_q);
    f_diff    = $signed({t_q[TW-1], t_q}) - $signed({held_temp_q[TW-1], held_temp_q});
    f_delta   = time_q - last_q;
    f_sum     = {1'b0, accum_q} + {1'b0, f_delta};
    f_sat     = f_sum[32] ? '1 : f_sum[31:0];
    f_take    = 1'b0;
    f_accum   = accum_q;
    f_last    = last_q;
    if (f_changed) begin
      f_last = time_q;
      if (st_q == ntcq_pkg::ST_VALID && held_st_q == ntcq_pkg::ST_VALID &&
          (f_diff == (TW+1)'(1) || f_diff == '1)) begin
        f_accum = f_sat;
        f_take  = f_sat >= hold_time_q;
      end else begin
        f_take = 1'b1;
      end
    end else begin
      f_accum = '0;
    end
    f_pend = pending_q || f_take;
    if (f_pend) begin
      f_accum = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      div_num_q   <= '0;
      bypass_q    <= '0;
      err_code_q  <= '1;
      offset_q    <= '0;
      hold_time_q <= '0;
      held_temp_q <= '0;
      held_st_q   <= ntcq_pkg::ST_VALID;
      accum_q     <= '0;
      last_q      <= '0;
      pending_q   <= 1'b1;
      out_valid_q <= 1'b0;
      out_temp_q  <= '0;
      out_st_q    <= '0;
      out_upd_q   <= 1'b0;
      out_reply_q <= 1'b0;
      req_q       <= 1'b0;
      time_q      <= '0;
      t_q         <= '0;
      r_q         <= '0;
      lo_q        <= '0;
      hi_q        <= '0;
      upd_q       <= 1'b0;
      st_q        <= ntcq_pkg::ST_VALID;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          ntcq_pkg::CFG_DIV_NUM:   div_num_q   <= cfg_data_i;
          ntcq_pkg::CFG_BYPASS:    bypass_q    <= cfg_data_i[ntcq_pkg::RB_W-1:0];
          ntcq_pkg::CFG_ERR_CODE:  err_code_q  <= cfg_data_i[ntcq_pkg::ADC_W-1:0];
          ntcq_pkg::CFG_OFFSET:    offset_q    <= cfg_data_i[ntcq_pkg::OFS_W-1:0];
          ntcq_pkg::CFG_HOLD_TIME: hold_time_q <= cfg_data_i;
          default: ;
        endcase
      end

      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            req_q  <= req_type_i;
            time_q <= time_ms_i;
            t_q    <= '0;
            upd_q  <= 1'b0;
            if (req_type_i) begin
              state_q <= S_OUT;
            end else if (adc_code_i == err_code_q) begin
              st_q    <= ntcq_pkg::ST_SENSOR;
              state_q <= S_FILTER;
            end else if (adc_code_i == '0) begin
              st_q    <= ntcq_pkg::ST_LOW;
              state_q <= S_FILTER;
            end else begin
              state_q <= S_DIV;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            r_q  <= r_full[RES_W-1:0];
            lo_q <= '0;
            hi_q <= IDX_W'(N - 1);
            if (r_full < R_MIN) begin
              st_q    <= ntcq_pkg::ST_HIGH;
              state_q <= S_FILTER;
            end else if (r_full > R_MAX) begin
              st_q    <= ntcq_pkg::ST_LOW;
              state_q <= S_FILTER;
            end else begin
              st_q    <= ntcq_pkg::ST_VALID;
              state_q <= S_SEARCH;
            end
          end
        end
        S_SEARCH: begin
          if (lo_q == hi_q) begin
            t_q     <= temp9[TW-1:0];
            state_q <= S_FILTER;
          end else if (mid_ok) begin
            lo_q <= mid;
          end else begin
            hi_q <= mid - 1'b1;
          end
        end
        S_FILTER: begin
          accum_q   <= f_accum;
          last_q    <= f_last;
          pending_q <= 1'b0;
          upd_q     <= f_pend;
          if (f_take) begin
            held_temp_q <= t_q;
            held_st_q   <= st_q;
          end
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            out_temp_q  <= held_temp_q;
            out_st_q    <= held_st_q;
            out_upd_q   <= upd_q;
            out_reply_q <= req_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign temperature_o = out_temp_q;
  assign status_o      = out_st_q;
  assign updated_o     = out_upd_q;
  assign is_reply_o    = out_reply_q;

endmodule

`default_nettype wire

>>> hw/rtl/ntcq_div.sv
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module ntcq_div (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [ntcq_pkg::NUM_W-1:0] dividend_i,
  input  wire logic [ntcq_pkg::ADC_W-1:0] divisor_i,
  output logic                            done_o,
  output logic [ntcq_pkg::NUM_W-1:0]      quotient_o
);

  localparam int CNT_W = $clog2(ntcq_pkg::NUM_W);
  localparam int ADC_W = ntcq_pkg::ADC_W;

  logic                 busy_q;
  logic                 done_q;
  logic [CNT_W-1:0]     cnt_q;
  logic [ntcq_pkg::NUM_W-1:0] quo_q;
  logic [ntcq_pkg::NUM_W-1:0] quo_d;
  logic [ADC_W-1:0]     div_q;
  logic [ADC_W-1:0]     rem_q;
  logic [ADC_W-1:0]     rem_d;
  logic [ADC_W:0]       rem_sh;
  logic [ADC_W:0]       rem_sub;
  logic                 fits;

  always_comb begin
    rem_sh  = {rem_q, quo_q[ntcq_pkg::NUM_W-1]};
    rem_sub = rem_sh - {1'b0, div_q};
    fits    = rem_sh >= {1'b0, div_q};
    rem_d   = fits ? rem_sub[ADC_W-1:0] : rem_sh[ADC_W-1:0];
    quo_d   = {quo_q[ntcq_pkg::NUM_W-2:0], fits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(ntcq_pkg::NUM_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      div_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

>>> hw/rtl/ntcq_checker.sv
`default_nettype none

`include "ntc_temperature_qualifier_defines.svh"

module ntcq_checker (
  input wire logic                           clk_i,
  input wire logic                           rst_ni,
  input wire logic                           in_valid_i,
  input wire logic                           in_ready_o,
  input wire logic                           out_valid_o,
  input wire logic                           out_ready_i,
  input wire logic signed [ntcq_pkg::TEMP_W-1:0] temperature_o,
  input wire logic [1:0]                     status_o,
  input wire logic                           updated_o,
  input wire logic                           is_reply_o
);

  logic in_fire;
  logic out_stall;
  logic out_err;

  assign in_fire   = in_valid_i && in_ready_o;
  assign out_stall = out_valid_o && !out_ready_i;
  assign out_err   = out_valid_o && (status_o != ntcq_pkg::ST_VALID);

  `NTCQ_ASSERT_NXT(a_out_hold, out_stall, out_valid_o && $stable(temperature_o))
  `NTCQ_ASSERT_IMP(a_reply_no_update, out_valid_o && is_reply_o, !updated_o)
  `NTCQ_ASSERT_IMP(a_error_zero_temp, out_err, temperature_o == '0)
  `NTCQ_ASSERT_NXT(a_one_at_a_time, in_fire, !in_ready_o)

endmodule

bind ntc_temperature_qualifier ntcq_checker u_ntcq_checker (.*);

`default_nettype wire

>>> verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import ntcq_pkg::*;

  typedef struct packed {
    logic signed [7:0] temp;
    status_e           status;
    logic              updated;
    logic              is_reply;
  } reading_t;

  typedef enum logic {ROW_ITEM, ROW_REG} row_kind_e;

  typedef struct packed {
    row_kind_e            kind;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [31:0]          reg_val;
    logic                 req;
    logic [15:0]          adc;
    logic [31:0]          tms;
    logic                 typed;
    logic signed [7:0]    temp;
    status_e              status;
    logic                 upd;
  } step_row_t;

  localparam int NUM_ENTRIES = 70;
  localparam int BASE_DEG    = -12;
  localparam int NUM_PHASES  = 6;
  localparam int PHASE_ITEMS = 90;

  localparam int RES_TABLE [NUM_ENTRIES] = '{
    12160, 11520, 10920, 10350, 9820, 9316, 8841, 8392, 7968, 7568,
    7190, 6833, 6495, 6175, 5873, 5587, 5315, 5060, 4818, 4589,
    4372, 4167, 3972, 3788, 3613, 3447, 3290, 3141, 2999, 2865,
    2737, 2616, 2501, 2391, 2287, 2188, 2094, 2005, 1919, 1838,
    1761, 1687, 1617, 1550, 1486, 1426, 1368, 1312, 1259, 1209,
    1161, 1115, 1071, 1029, 989, 951, 914, 879, 845, 813,
    783, 753, 725, 698, 672, 647, 624, 601, 579, 559
  };

  localparam int NUM_ROWS = 36;
  localparam step_row_t DIRECTED [NUM_ROWS] = '{
    '{ROW_ITEM, CFG_DIV_NUM, 32'd0, 1'b1, 16'd0, 32'd0, 1'b1, 8'sd0, ST_VALID, 1'b0},
    '{ROW_ITEM, CFG_DIV_NUM, 32'd0, 1'b0, 16'd0, 32'd5, 1'b1, 8'sd0, ST_LOW, 1'b1},
    '{ROW_ITEM, CFG_DIV_NUM, 32'd0, 1'b0, 16'hFFFF, 32'd9, 1'b1, 8'sd0, ST_SENSOR, 1'b1},
    '{ROW_ITEM, CFG_DIV_NUM, 32'd0, 1'b0, 16'd1000, 32'd12, 1'b1, 8'sd0, ST_HIGH, 1'b1},
    '{ROW_ITEM, CFG_DIV_NUM, 32'd0, 1'b0, 16'd1000, 32'd20, 1'b1, 8'sd0, ST_HIGH, 1'b0},
    '{ROW_REG, CFG_DIV_NUM, 32'd12160, 1'b0, 16'd0, 32'd0, 1'b0, 8'sd0, ST_VALID, 1'b0},
    '{ROW_REG, CFG_ERR_CODE, 32'd0, 1'b0, 16'd0, 32'd0, 1'b0, 8'sd0, ST_VALID, 1'b0},
    '{ROW_REG, CFG_HOLD_TIME, 32'd100, 1'b0, 16'd0, 32'd0, 1'b0, 8'sd0, ST_VALID, 1'b0},
    // error code of zero wins over the zero-code rule
    '{ROW_ITEM, CFG_DIV_NUM, 32'd0, 1'b0, 16'd0, 32'd30, 1'b1, 8'sd0, ST_SENSOR, 1'b1},
    '{ROW_ITEM, CFG_DIV_NUM, 32'd0, 1'b0, 16'd1, 32'd1000, 1'b1, -8'sd12, ST_VALID, 1'b1},
    '{ROW_ITEM, CFG_DIV_NUM, 32'd0, 1'b0, 16'd2, 32'd1010, 1'b0, 8'sd0, ST_VALID, 1'b0},
    '{ROW_ITEM, CFG_DIV_NUM, 32'd0, 1'b1, 16'hFFFF, 32'hFFFF_FFFF, 1'b0, 8'sd0, ST_VALID,
      1'b0},
    '{ROW_REG, CFG_DIV_NUM, 32'd12161, 1'b0, 16'd0, 32'd0, 1'b0, 8'sd0, ST_VALID, 1'b0},
    '{ROW_ITEM, CFG_DIV_NUM, 32'd0, 1'b0, 16'd1, 32'd1100, 1'b1, 8'sd0, ST_LOW, 1'b1},
    '{ROW_REG, CFG_DIV_NUM, 32'd12160, 1'b0, 16'd0, 32'd0, 1'b0, 8'sd0, ST_VALID, 1'b0},
    '{ROW_REG, CFG_BYPASS, 32'd11601, 1'b0, 16'd0, 32'd0, 1'b0, 8'sd0, ST_VALID, 1'b0},
    // r lands exactly on the last table entry
    '{ROW_ITEM, CFG_DIV_NUM, 32'd0, 1'b0, 16'd1, 32'd1200, 1'b1, 8'sd57, ST_VALID, 1'b1},
    '{ROW_REG, CFG_BYPASS, 32'd11602, 1'b0, 16'd0, 32'd0, 1'b0, 8'sd0, ST_VALID, 1'b0},
    '{ROW_ITEM, CFG_DIV_NUM, 32'd0, 1'b0, 16'd1, 32'd1300, 1'b1, 8'sd0, ST_HIGH, 1'b1},
    '{ROW_REG, CFG_BYPASS, 32'h000F_FFFF, 1'b0, 16'd0, 32'd0, 1'b0, 8'sd0, ST_VALID, 1'b0},
    // negative r
    '{ROW_ITEM, CFG_DIV_NUM, 32'd0, 1'b0, 16'd1, 32'd1400, 1'b1, 8'sd0, ST_HIGH, 1'b0},
    '{ROW_REG, CFG_BYPASS, 32'd0, 1'b0, 16'd0, 32'd0, 1'b0, 8'sd0, ST_VALID, 1'b0},
    '{ROW_REG, CFG_DIV_NUM, 32'd1200000, 1'b0, 16'd0, 32'd0, 1'b0, 8'sd0, ST_VALID, 1'b0},
    '{ROW_REG, CFG_OFFSET, 32'd15, 1'b0, 16'd0, 32'd0, 1'b0, 8'sd0, ST_VALID, 1'b0},
    '{ROW_ITEM, CFG_DIV_NUM, 32'd0, 1'b0, 16'd100, 32'd1000, 1'b1, 8'sd3, ST_VALID, 1'b1},
    // one-degree step held back, then accepted once enough time builds up
    '{ROW_ITEM, CFG_DIV_NUM, 32'd0, 1'b0, 16'd105, 32'd1050, 1'b0, 8'sd0, ST_VALID, 1'b0},
    '{ROW_ITEM, CFG_DIV_NUM, 32'd0, 1'b0, 16'd105, 32'd1120, 1'b0, 8'sd0, ST_VALID, 1'b0},
    '{ROW_ITEM, CFG_DIV_NUM, 32'd0, 1'b0, 16'd105, 32'd1130, 1'b0, 8'sd0, ST_VALID, 1'b0},
    '{ROW_REG, CFG_OFFSET, 32'h10, 1'b0, 16'd0, 32'd0, 1'b0, 8'sd0, ST_VALID, 1'b0},
    '{ROW_REG, CFG_HOLD_TIME, 32'hFFFF_FFFF, 1'b0, 16'd0, 32'd0, 1'b0, 8'sd0, ST_VALID,
      1'b0},
    '{ROW_ITEM, CFG_DIV_NUM, 32'd0, 1'b0, 16'd100, 32'd0, 1'b1, -8'sd28, ST_VALID, 1'b1},
    '{ROW_ITEM, CFG_DIV_NUM, 32'd0, 1'b0, 16'd105, 32'hFFFF_FFFF, 1'b0, 8'sd0, ST_VALID,
      1'b0},
    // time going backward drives the accumulator into saturation
    '{ROW_ITEM, CFG_DIV_NUM, 32'd0, 1'b0, 16'd100, 32'd16, 1'b0, 8'sd0, ST_VALID, 1'b0},
    '{ROW_ITEM, CFG_DIV_NUM, 32'd0, 1'b0, 16'd100, 32'd8, 1'b0, 8'sd0, ST_VALID, 1'b0},
    '{ROW_ITEM, CFG_DIV_NUM, 32'd0, 1'b1, 16'd77, 32'd40, 1'b0, 8'sd0, ST_VALID, 1'b0},
    '{ROW_ITEM, CFG_DIV_NUM, 32'd0, 1'b0, 16'hFFFF, 32'd50, 1'b0, 8'sd0, ST_VALID, 1'b0}
  };

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = CFG_DIV_NUM;
  logic [CFG_W-1:0]      cfg_data_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  logic                  req_type_i = 1'b0;
  logic [ADC_W-1:0]      adc_code_i = '0;
  logic [31:0]           time_ms_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic signed [TEMP_W-1:0] temperature_o;
  logic [1:0]            status_o;
  logic                  updated_o;
  logic                  is_reply_o;

  ntc_temperature_qualifier dut (.*);

  always #5 clk_i = ~clk_i;

  // register mirror
  logic [31:0] k_num    = '0;
  logic [19:0] rb_ohm   = '0;
  logic [15:0] err_code = 16'hFFFF;
  int          ofs_deg  = 0;
  logic [31:0] hold_ms  = '0;

  // filter state
  int          held_deg       = 0;
  status_e     held_state     = ST_VALID;
  logic [31:0] accum_ms       = '0;
  logic [31:0] last_change_ms = '0;
  bit          publish_due    = 1'b1;

  reading_t pending_readings[$];

  int src_idle_pct = 0;
  int snk_idle_pct = 0;
  int n_items      = 0;
  int n_results    = 0;
  int n_replies    = 0;
  int n_updates    = 0;
  int mismatches   = 0;
  int status_seen [4] = '{0, 0, 0, 0};

  function automatic void lookup_temp(input logic [15:0] adc, output status_e st,
                                      output int deg);
    longint r;
    int idx;
    deg = 0;
    if (adc == err_code) begin
      st = ST_SENSOR;
    end else if (adc == 16'd0) begin
      st = ST_LOW;
    end else begin
      r = longint'({32'd0, k_num / {16'd0, adc}}) - longint'({44'd0, rb_ohm});
      if (r < RES_TABLE[NUM_ENTRIES-1]) begin
        st = ST_HIGH;
      end else if (r > RES_TABLE[0]) begin
        st = ST_LOW;
      end else begin
        idx = 0;
        for (int i = 0; i < NUM_ENTRIES; i++) begin
          if (RES_TABLE[i] >= r) idx = i;
        end
        st = ST_VALID;
        deg = BASE_DEG + idx + ofs_deg;
      end
    end
  endfunction

  function automatic reading_t qualify_sample(input logic rt, input logic [15:0] adc,
                                              input logic [31:0] now);
    reading_t res;
    status_e st;
    int deg;
    logic [31:0] delta;
    bit upd;
    upd = 1'b0;
    if (!rt) begin
      lookup_temp(adc, st, deg);
      if (st != held_state || deg != held_deg) begin
        delta = now - last_change_ms;
        last_change_ms = now;
        if (st == ST_VALID && held_state == ST_VALID &&
            (deg - held_deg == 1 || deg - held_deg == -1)) begin
          accum_ms = (accum_ms > 32'hFFFF_FFFF - delta) ? 32'hFFFF_FFFF : accum_ms + delta;
          if (accum_ms >= hold_ms) begin
            held_deg = deg;
            held_state = st;
            publish_due = 1'b1;
          end
        end else begin
          held_deg = deg;
          held_state = st;
          publish_due = 1'b1;
        end
      end else begin
        accum_ms = '0;
      end
      if (publish_due) begin
        upd = 1'b1;
        accum_ms = '0;
        publish_due = 1'b0;
      end
    end
    res.temp = 8'(held_deg);
    res.status = held_state;
    res.updated = upd;
    res.is_reply = rt;
    return res;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    case (idx)
      CFG_DIV_NUM:   k_num = data;
      CFG_BYPASS:    rb_ohm = data[19:0];
      CFG_ERR_CODE:  err_code = data[15:0];
      CFG_OFFSET:    ofs_deg = int'($signed(data[4:0]));
      CFG_HOLD_TIME: hold_ms = data;
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain_readings();
    in_valid_i <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic send_item(input logic rt, input logic [15:0] adc, input logic [31:0] tms,
                           input logic typed, input reading_t typed_res);
    reading_t predicted;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= rt;
    adc_code_i <= adc;
    time_ms_i <= tms;
    @(negedge clk_i);
    while (!in_ready_o) @(negedge clk_i);
    @(posedge clk_i);
    predicted = qualify_sample(rt, adc, tms);
    pending_readings.push_back(typed ? typed_res : predicted);
    n_items++;
  endtask

  always @(posedge clk_i) out_ready_i <= ($urandom_range(0, 99) >= snk_idle_pct);

  always @(negedge clk_i) begin : check_out
    reading_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      n_results++;
      n_replies += is_reply_o;
      n_updates += updated_o;
      status_seen[status_o]++;
      if (pending_readings.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: temp %0d status %0d upd %0b reply %0b",
                   temperature_o, status_o, updated_o, is_reply_o);
      end else begin
        want = pending_readings.pop_front();
        if (temperature_o !== want.temp || status_o !== want.status ||
            updated_o !== want.updated || is_reply_o !== want.is_reply) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp temp %0d status %0d upd %0b reply %0b, got %0d %0d %0b %0b",
                     want.temp, want.status, want.updated, want.is_reply,
                     temperature_o, status_o, updated_o, is_reply_o);
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    int mid, walk, step, pick, n_dir;
    logic [31:0] k, now_ms;
    logic [19:0] rb;
    logic [15:0] err, adc;
    logic rt;
    now_ms = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    src_idle_pct = 35;
    snk_idle_pct = 59;
    foreach (DIRECTED[i]) begin
      if (DIRECTED[i].kind == ROW_REG) begin
        drain_readings();
        write_reg(DIRECTED[i].reg_idx, DIRECTED[i].reg_val);
      end else begin
        send_item(DIRECTED[i].req, DIRECTED[i].adc, DIRECTED[i].tms, DIRECTED[i].typed,
                  '{DIRECTED[i].temp, DIRECTED[i].status, DIRECTED[i].upd, DIRECTED[i].req});
      end
    end
    n_dir = n_items;

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph == 2) begin
        src_idle_pct = 59;
        snk_idle_pct = 35;
      end else if (ph == 4) begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end
      drain_readings();
      // aim the divider so that codes around mid land inside the table
      mid = $urandom_range(50, 3000);
      rb = ph[0] ? 20'($urandom_range(0, 3000)) : 20'd0;
      k = ($urandom_range(600, 12500) + rb) * mid;
      case ($urandom_range(0, 2))
        0:       err = 16'hFFFF;
        1:       err = 16'h0000;
        default: err = 16'($urandom);
      endcase
      if (ph == 5) begin
        k = 32'hFFFF_FFFF;
        rb = 20'hFFFFF;
        mid = 4073;
      end
      write_reg(CFG_DIV_NUM, k);
      write_reg(CFG_BYPASS, {12'd0, rb});
      write_reg(CFG_ERR_CODE, {16'd0, err});
      write_reg(CFG_OFFSET, 32'($urandom_range(0, 31)));
      write_reg(CFG_HOLD_TIME, (ph == 5) ? 32'hFFFF_FFFF :
                               (ph == 3) ? 32'd0 : 32'($urandom_range(0, 300)));
      walk = mid;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 1 && n == PHASE_ITEMS / 2) drain_readings();
        pick = $urandom_range(0, 99);
        rt = 1'b0;
        step = $urandom_range(0, mid / 20 + 1);
        walk = $urandom_range(0, 1) ? walk + step : walk - step;
        if (walk < mid / 2) walk = mid / 2;
        if (walk > mid * 2) walk = mid * 2;
        if (pick < 10) begin
          rt = 1'b1;
          adc = 16'($urandom);
        end else if (pick < 15) begin
          adc = err_code;
        end else if (pick < 18) begin
          adc = 16'd0;
        end else if (pick < 24) begin
          adc = 16'($urandom);
        end else begin
          adc = 16'(walk);
        end
        if ($urandom_range(0, 39) == 0) now_ms = $urandom;
        else now_ms = now_ms + $urandom_range(0, 160);
        send_item(rt, adc, now_ms, 1'b0, '0);
      end
    end

    drain_readings();
    repeat (100) @(posedge clk_i);
    $display("%0d items (%0d directed, rest random over %0d register settings)",
             n_items, n_dir, NUM_PHASES);
    $display("%0d results: %0d replies, %0d updates, valid/sensor/high/low %0d/%0d/%0d/%0d",
             n_results, n_replies, n_updates, status_seen[0], status_seen[1],
             status_seen[2], status_seen[3]);
    if (mismatches == 0 && pending_readings.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
